// ----- rtl/dss_pkg.sv -----
// Package for the disk seek scheduler: constants, codes and controller/datapath structs.
// No dependencies.
package dss_pkg;
	localparam int MAX_REQUESTS = 32;
	localparam int IDX_W = $clog2(MAX_REQUESTS);
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int CYL_W = 16;
	localparam int TOT_W = 22;

	localparam logic [1:0] ALG_FCFS = 2'd0;
	localparam logic [1:0] ALG_SCAN = 2'd1;
	localparam logic [1:0] ALG_CSCAN = 2'd2;
	localparam logic [1:0] ALG_RESERVED = 2'd3;

	localparam logic [1:0] REG_ALGORITHM = 2'd0;
	localparam logic [1:0] REG_START = 2'd1;
	localparam logic [1:0] REG_CYLINDERS = 2'd2;

	// move target kinds
	localparam logic [1:0] TGT_STORE = 2'd0;
	localparam logic [1:0] TGT_TOP = 2'd1;
	localparam logic [1:0] TGT_ZERO = 2'd2;

	typedef struct packed {
		logic load;          // write request into store
		logic sort_clr;      // begin selection pass
		logic sort_step;     // examine one entry of the store
		logic [1:0] tgt;     // kind of move target
		logic batch_clr;     // clear count, overflow, total, used flags
		logic head_init;     // head <= start cylinder
		logic last;          // last move of the schedule
	} dss_cmd_t;

	typedef struct packed {
		logic found;         // best candidate found in pass
		logic best_up;       // best candidate lies above the start head
		logic scan_done;     // pass index at final entry
		logic [CNT_W-1:0] count;
	} dss_sts_t;
endpackage

// ----- rtl/dss_ram.sv -----
// Generic single-port write, one-read RAM with registered read.
// No dependencies.
module dss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/dss_datapath.sv -----
// Datapath: request RAM, used flags, selection search, head/total and output regs.
// Depends on dss_pkg and dss_ram.
module dss_datapath import dss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dss_cmd_t          cmd,
	output dss_sts_t          sts,
	input  logic [CYL_W-1:0]  in_cyl,
	input  logic [1:0]        algorithm,
	input  logic [CYL_W-1:0]  start_cyl,
	input  logic [16:0]       disk_cyl,
	input  logic              out_load,
	output logic [CYL_W-1:0]  o_from,
	output logic [CYL_W-1:0]  o_to,
	output logic [CYL_W-1:0]  o_dist,
	output logic [TOT_W-1:0]  o_total,
	output logic              o_ovf,
	output logic              o_last
);
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic [TOT_W-1:0] total_q;
	logic [CYL_W-1:0] head_q, base_q;
	logic [MAX_REQUESTS-1:0] used_q;
	logic [IDX_W-1:0] ridx_q, sidx_s1, best_idx_q;
	logic step_s1;
	logic found_q, best_up_q;
	logic [CYL_W-1:0] best_q, rdata;
	logic [CYL_W-1:0] top;
	logic [CYL_W-1:0] o_to_n, dist_n;

	always_comb begin
		if (disk_cyl == 17'd0) top = '0;
		else if (disk_cyl > 17'd65536) top = 16'hFFFF;
		else top = 16'(disk_cyl - 17'd1);
	end

	// requests past a full store are dropped, not written
	dss_ram #(.WIDTH(CYL_W), .DEPTH(MAX_REQUESTS)) u_ram (
		.clk(clk), .we(cmd.load && (count_q < CNT_W'(MAX_REQUESTS))),
		.waddr(count_q[IDX_W-1:0]), .wdata(in_cyl),
		.raddr(ridx_q), .rdata(rdata)
	);

	// candidate rank: FCFS takes lowest index; SCAN upper asc then lower desc;
	// CSCAN upper asc then lower asc. base_q is the start head.
	logic cand_up, better;
	always_comb begin
		cand_up = rdata > base_q;
		better = 1'b0;
		if (!used_q[sidx_s1]) begin
			if (!found_q) better = 1'b1;
			else if (algorithm == ALG_SCAN || algorithm == ALG_CSCAN) begin
				if (cand_up != best_up_q) better = cand_up;
				else if (cand_up || algorithm == ALG_CSCAN) better = rdata < best_q;
				else better = rdata > best_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; ovf_q <= 1'b0; total_q <= '0; head_q <= '0;
			used_q <= '0; ridx_q <= '0; step_s1 <= 1'b0; found_q <= 1'b0;
		end else begin
			step_s1 <= cmd.sort_step;
			if (cmd.load) begin
				if (count_q < CNT_W'(MAX_REQUESTS)) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.head_init) head_q <= start_cyl;
			if (cmd.sort_clr) begin
				ridx_q <= '0; found_q <= 1'b0;
			end
			if (cmd.sort_step) ridx_q <= ridx_q + 1'b1;
			if (step_s1 && better) found_q <= 1'b1;
			if (out_load) begin
				head_q <= o_to_n;
				total_q <= total_q + TOT_W'(dist_n);
				if (cmd.tgt == TGT_STORE) used_q[best_idx_q] <= 1'b1;
			end
			if (cmd.batch_clr) begin
				count_q <= '0; ovf_q <= 1'b0; total_q <= '0; used_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.head_init) base_q <= start_cyl;
		if (cmd.sort_step) sidx_s1 <= ridx_q;
		if (step_s1 && better) begin
			best_q <= rdata; best_up_q <= cand_up; best_idx_q <= sidx_s1;
		end
	end

	always_comb begin
		case (cmd.tgt)
			TGT_TOP:  o_to_n = top;
			TGT_ZERO: o_to_n = '0;
			default:  o_to_n = best_q;
		endcase
		dist_n = (head_q > o_to_n) ? head_q - o_to_n : o_to_n - head_q;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_from <= head_q; o_to <= o_to_n; o_dist <= dist_n;
			o_total <= total_q + TOT_W'(dist_n); o_ovf <= ovf_q; o_last <= cmd.last;
		end
	end

	assign sts.found = found_q;
	assign sts.best_up = best_up_q;
	assign sts.scan_done = step_s1 && (sidx_s1 == IDX_W'(count_q - 1'b1));
	assign sts.count = count_q;
endmodule

// ----- rtl/dss_ctrl.sv -----
// Controller: load, per-move selection pass, emission and output handshake.
// Depends on dss_pkg.
module dss_ctrl import dss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] algorithm,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       out_load,
	input  dss_sts_t   sts,
	output dss_cmd_t   cmd
);
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_END = 3'd4;

	logic [2:0] state_q;
	logic [CNT_W-1:0] moves_q;   // store moves taken
	logic top_done_q, zero_done_q, valid_q;
	logic cscan;
	logic slot;
	assign cscan = algorithm == ALG_CSCAN;
	assign slot = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign in_ready = state_q == ST_LOAD;

	logic [1:0] tgt;
	logic last_move, need_top, store_left;
	always_comb begin
		store_left = moves_q != sts.count;
		need_top = (algorithm == ALG_SCAN || cscan) && !top_done_q;
		tgt = TGT_STORE;
		// upper requests go before top; the found best is upper only when rank says so
		if (need_top && (!store_left || !sts.best_up)) tgt = TGT_TOP;
		else if (cscan && top_done_q && !zero_done_q) tgt = TGT_ZERO;
		last_move = 1'b0;
		case (tgt)
			TGT_TOP:  last_move = !cscan && !store_left;
			TGT_ZERO: last_move = !store_left;
			default:  last_move = (moves_q + 1'b1 == sts.count) && !need_top;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.head_init = (in_valid && in_ready && in_last) || (state_q == ST_END);
		cmd.sort_clr = state_q == ST_EMIT && out_load;
		// no step once the final entry is in the compare stage
		cmd.sort_step = state_q == ST_SCAN && !sts.scan_done;
		cmd.tgt = tgt;
		cmd.last = last_move;
		cmd.batch_clr = state_q == ST_END;
	end
	assign out_load = state_q == ST_EMIT && slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; moves_q <= '0; top_done_q <= 1'b0;
			zero_done_q <= 1'b0; valid_q <= 1'b0;
		end else begin
			if (out_load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: if (cmd.load && in_last) begin
					moves_q <= '0; top_done_q <= 1'b0; zero_done_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: if (sts.scan_done || !store_left) state_q <= ST_WAIT;
				ST_WAIT: state_q <= ST_EMIT;
				ST_EMIT: if (out_load) begin
					if (tgt == TGT_STORE) moves_q <= moves_q + 1'b1;
					if (tgt == TGT_TOP) top_done_q <= 1'b1;
					if (tgt == TGT_ZERO) zero_done_q <= 1'b1;
					state_q <= last_move ? ST_END : ST_SCAN;
				end
				ST_END: state_q <= ST_LOAD;
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- rtl/disk_seek_scheduler_unit.sv -----
// Disk seek scheduler (FCFS, SCAN, C-SCAN).
// Channels: s_axis carries requests {cylinder} with tlast = last_request.
// Requests are taken one per cycle. The request with tlast closes the batch;
// the block then stops taking requests and sends the schedule on m_axis,
// one move per result, tlast on the final move.
// Each move needs a selection pass over the stored requests (store RAM
// read, one entry a cycle). The result sits in an output register; a
// stalled receiver holds the controller in its emit state until the slot
// frees. Configuration is written through cfg_we/cfg_addr/cfg_wdata;
// the user must write it only while idle, as the block does not check.
// Reset: FCFS, start cylinder 0, 65536 cylinders, empty batch.
// Depends on dss_pkg, dss_ctrl, dss_datapath, dss_ram.
module disk_seek_scheduler_unit import dss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [16:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cylinder
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // move_from, move_to, move_distance, total_movement
	output logic        m_axis_tuser,  // overflow
	output logic        m_axis_tlast
);
	logic [1:0] alg_q;
	logic [15:0] start_q;
	logic [16:0] cyl_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= ALG_FCFS; start_q <= '0; cyl_q <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ALGORITHM: alg_q <= cfg_wdata[1:0];
				REG_START:     start_q <= cfg_wdata[15:0];
				REG_CYLINDERS: cyl_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dss_cmd_t cmd;
	dss_sts_t sts;
	logic out_load;
	logic [15:0] f, t, d;
	logic [21:0] tot;

	dss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .algorithm(alg_q),
		.in_valid(s_axis_tvalid), .in_last(s_axis_tlast), .in_ready(s_axis_tready),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .out_load(out_load),
		.sts(sts), .cmd(cmd)
	);

	dss_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_cyl(s_axis_tdata),
		.algorithm(alg_q), .start_cyl(start_q), .disk_cyl(cyl_q), .out_load(out_load),
		.o_from(f), .o_to(t), .o_dist(d), .o_total(tot), .o_ovf(m_axis_tuser),
		.o_last(m_axis_tlast)
	);
	assign m_axis_tdata = {2'b00, tot, d, t, f};
endmodule

// ----- rtl/dss_checker.sv -----
// Port-level checker for disk_seek_scheduler_unit, bound to the top level.
// Depends on nothing beyond the top-level ports.
module dss_port_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast,
	input logic [71:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
	a_noload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready || $past(m_axis_tvalid && m_axis_tlast))
		else $error("request taken during schedule");
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[47:32] ==
		((m_axis_tdata[15:0] > m_axis_tdata[31:16]) ?
		m_axis_tdata[15:0] - m_axis_tdata[31:16] : m_axis_tdata[31:16] - m_axis_tdata[15:0]))
		else $error("distance mismatch");
endmodule

bind disk_seek_scheduler_unit dss_port_checker u_chk (.*);
